[rtl/core/name_address_cache_with_expiry_assert.svh]
// assertion helpers used by the cache back end
`ifndef NAME_ADDRESS_CACHE_WITH_EXPIRY_ASSERT_SVH
`define NAME_ADDRESS_CACHE_WITH_EXPIRY_ASSERT_SVH

// same-cycle implication
`define NACE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NACE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/nace_pkg.sv]
`default_nettype none

package nace_pkg;

   localparam int ENTRIES_DEFAULT      = 8;
   localparam int MAX_NAME_LEN_DEFAULT = 64;

   localparam int KEY_W   = 64;
   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int LEN_W   = 10;
   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 6;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd300;
   localparam logic [TIME_W-1:0] STAMP_START   = 32'hffff_ffff;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic REG_MAX_AGE = 1'b0;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOOKUP,
      OP_INSERT,
      OP_CLEAR
   } op_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  name_key;
      logic [LEN_W-1:0]  name_length;
      logic [ADDR_W-1:0] new_address;
      logic [TIME_W-1:0] now;
   } req_word_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] address;
      logic              stored;
      logic [SLOT_W-1:0] slot;
   } rsp_word_type;

   typedef struct packed {
      op_kind_type       op;
      logic              keep;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] now;
   } op_word_type;

endpackage

`default_nettype wire

[rtl/core/nace_front.sv]
`default_nettype none

module nace_front #(
   parameter int MAX_NAME_LEN = nace_pkg::MAX_NAME_LEN_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  nace_pkg::req_word_type req_data,
   output logic                 op_valid,
   input  wire                  op_ready,
   output nace_pkg::op_word_type op_word
);

   localparam logic [nace_pkg::LEN_W-1:0] LEN_LIMIT = nace_pkg::LEN_W'(MAX_NAME_LEN - 1);

   nace_pkg::op_word_type op_class;
   nace_pkg::op_word_type hold_ff, hold_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic                  len_short;
   logic                  accept;

   // classify the incoming word
   always_comb begin
      len_short        = req_data.name_length < LEN_LIMIT;
      op_class.key     = req_data.name_key;
      op_class.address = req_data.new_address;
      op_class.now     = req_data.now;
      op_class.keep    = req_data.name_length != '0;
      case (req_data.kind)
         nace_pkg::KIND_LOOKUP: begin
            op_class.op = (op_class.keep && len_short) ? nace_pkg::OP_LOOKUP : nace_pkg::OP_NONE;
         end
         nace_pkg::KIND_INSERT: begin
            op_class.op = len_short ? nace_pkg::OP_INSERT : nace_pkg::OP_NONE;
         end
         nace_pkg::KIND_CLEAR: begin
            op_class.op = nace_pkg::OP_CLEAR;
         end
         default: begin
            op_class.op = nace_pkg::OP_NONE;
         end
      endcase
   end

   assign req_ready = !hold_valid_ff || op_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hold_valid_in = accept ? 1'b1 : (op_ready ? 1'b0 : hold_valid_ff);
      hold_in       = accept ? op_class : hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign op_valid = hold_valid_ff;
   assign op_word  = hold_ff;

endmodule

`default_nettype wire

[rtl/core/nace_queue.sv]
`default_nettype none

module nace_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   output logic                  push_ready,
   input  nace_pkg::op_word_type push_word,
   output logic                  pop_valid,
   input  wire                   pop_ready,
   output nace_pkg::op_word_type pop_word
);

   localparam int DEPTH = nace_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   nace_pkg::op_word_type slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push, pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

[rtl/core/nace_back.sv]
`default_nettype none
`include "name_address_cache_with_expiry_assert.svh"

module nace_back #(
   parameter int ENTRIES = nace_pkg::ENTRIES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [nace_pkg::TIME_W-1:0]   max_age,
   input  wire                          pop_valid,
   output logic                         pop_ready,
   input  nace_pkg::op_word_type        pop_word,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output nace_pkg::rsp_word_type       rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   nace_pkg::back_state_type state_ff, state_in;
   nace_pkg::op_word_type    op_ff;

   logic [ENTRIES-1:0]          entry_valid_ff, entry_valid_in;
   logic [nace_pkg::KEY_W-1:0]  entry_key_ff     [ENTRIES];
   logic [nace_pkg::ADDR_W-1:0] entry_address_ff [ENTRIES];
   logic [nace_pkg::TIME_W-1:0] entry_stamp_ff   [ENTRIES];

   logic [ENTRIES-1:0]          hit_vec_ff, hit_vec_in;
   logic [ENTRIES-1:0]          stale_vec_ff, stale_vec_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            victim_ff, victim_in;
   logic [nace_pkg::TIME_W-1:0] oldest_ff, oldest_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   nace_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   logic                        out_free;
   logic                        pop_fire;
   logic                        any_free;
   logic [IDX_W-1:0]            first_free;
   logic [IDX_W-1:0]            hit_idx;
   logic                        rsp_load;
   logic                        entry_we;
   logic                        valid_clear;
   logic                        valid_kill;
   logic                        scan_older;
   logic [nace_pkg::TIME_W-1:0] lane_limit [ENTRIES];

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop_fire   = (state_ff == nace_pkg::ST_IDLE) && pop_valid;
   assign any_free   = ~&entry_valid_ff;
   assign scan_older = entry_stamp_ff[idx_ff] < oldest_ff;

   // first empty entry
   always_comb begin
      first_free = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!entry_valid_ff[i]) begin
            first_free = IDX_W'(i);
         end
      end
   end

   // per-entry key match and freshness
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         lane_limit[i]   = entry_stamp_ff[i] + max_age;
         hit_vec_in[i]   = entry_valid_ff[i] && (entry_key_ff[i] == pop_word.key) &&
                           (lane_limit[i] > pop_word.now);
         stale_vec_in[i] = entry_valid_ff[i] && (entry_key_ff[i] == pop_word.key) &&
                           !(lane_limit[i] > pop_word.now);
      end
   end

   // last fresh match wins
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nace_pkg::ST_IDLE: begin
            if (pop_valid) begin
               case (pop_word.op)
                  nace_pkg::OP_LOOKUP: state_in = nace_pkg::ST_LOOK;
                  nace_pkg::OP_INSERT: state_in = any_free ? nace_pkg::ST_WRITE : nace_pkg::ST_SCAN;
                  default:             state_in = nace_pkg::ST_DONE;
               endcase
            end
         end
         nace_pkg::ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = nace_pkg::ST_WRITE;
            end
         end
         nace_pkg::ST_LOOK, nace_pkg::ST_WRITE, nace_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = nace_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nace_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop_ready   = 1'b0;
      rsp_load    = 1'b0;
      entry_we    = 1'b0;
      valid_clear = 1'b0;
      valid_kill  = 1'b0;
      rsp_word_in = '0;
      case (state_ff)
         nace_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
         end
         nace_pkg::ST_LOOK: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               valid_kill  = 1'b1;
               rsp_word_in.hit = |hit_vec_ff;
               if (|hit_vec_ff) begin
                  rsp_word_in.address = entry_address_ff[hit_idx];
                  rsp_word_in.slot    = nace_pkg::SLOT_W'(hit_idx);
               end
            end
         end
         nace_pkg::ST_WRITE: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               entry_we           = 1'b1;
               rsp_word_in.stored = op_ff.keep;
               if (op_ff.keep) begin
                  rsp_word_in.slot = nace_pkg::SLOT_W'(victim_ff);
               end
            end
         end
         nace_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               valid_clear = op_ff.op == nace_pkg::OP_CLEAR;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      victim_in = victim_ff;
      oldest_in = oldest_ff;
      if (pop_fire) begin
         idx_in    = '0;
         victim_in = first_free;
         oldest_in = nace_pkg::STAMP_START;
      end else if (state_ff == nace_pkg::ST_SCAN) begin
         if (idx_ff != LAST_IDX) begin
            idx_in = idx_ff + 1'b1;
         end
         if (scan_older) begin
            victim_in = idx_ff;
            oldest_in = entry_stamp_ff[idx_ff];
         end
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (valid_clear) begin
         entry_valid_in = '0;
      end
      if (valid_kill) begin
         entry_valid_in = entry_valid_in & ~stale_vec_ff;
      end
      if (entry_we) begin
         entry_valid_in[victim_ff] = op_ff.keep;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= nace_pkg::ST_IDLE;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      victim_ff <= victim_in;
      oldest_ff <= oldest_in;
      if (pop_fire) begin
         op_ff        <= pop_word;
         hit_vec_ff   <= hit_vec_in;
         stale_vec_ff <= stale_vec_in;
      end
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (entry_we) begin
         entry_key_ff[victim_ff]     <= op_ff.key;
         entry_address_ff[victim_ff] <= op_ff.address;
         entry_stamp_ff[victim_ff]   <= op_ff.now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   `NACE_ASSERT_NOW(a_scan_only_when_full, clock, reset, state_ff == nace_pkg::ST_SCAN, &entry_valid_ff, "victim scan with a free entry")
   `NACE_ASSERT_NOW(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_word_ff.hit, rsp_word_ff.address == '0, "miss carries an address")
   `NACE_ASSERT_NOW(a_hit_xor_store, clock, reset, rsp_valid_ff, !(rsp_word_ff.hit && rsp_word_ff.stored), "hit and stored together")
   `NACE_ASSERT_NEXT(a_store_sets_valid, clock, reset, entry_we && op_ff.keep, entry_valid_ff[$past(victim_ff)], "stored entry left invalid")

endmodule

`default_nettype wire

[rtl/core/name_address_cache_with_expiry.sv]
// lookup, clear and insert with a free entry: the request word passes the front hold register,
// the queue slot and the back-end sequencer before the result register
// the back-end sequencer pops a word, executes it once the result register is free, then returns to idle
// a full-cache insert also holds the back end in a scan over every entry for the oldest stamp
// reset: empties the cache (entry valid bits), the queue and the result register, max_age = 300
`default_nettype none

module name_address_cache_with_expiry #(
   parameter int ENTRIES      = nace_pkg::ENTRIES_DEFAULT,
   parameter int MAX_NAME_LEN = nace_pkg::MAX_NAME_LEN_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  nace_pkg::req_word_type           req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output nace_pkg::rsp_word_type           rsp_data,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [nace_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire [nace_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [nace_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   logic [nace_pkg::TIME_W-1:0] max_age_ff, max_age_in;
   logic                        csr_write;

   logic                  front_valid, front_ready;
   nace_pkg::op_word_type front_word;
   logic                  queue_valid, queue_ready;
   nace_pkg::op_word_type queue_word;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      max_age_in = max_age_ff;
      if (csr_write && (paddr[2] == nace_pkg::REG_MAX_AGE)) begin
         max_age_in = pwdata;
      end
      prdata = (paddr[2] == nace_pkg::REG_MAX_AGE) ? max_age_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= nace_pkg::MAX_AGE_RESET;
      end else begin
         max_age_ff <= max_age_in;
      end
   end

   nace_front #(
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (front_valid),
      .op_ready  (front_ready),
      .op_word   (front_word)
   );

   nace_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_word  (front_word),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_word   (queue_word)
   );

   nace_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .max_age   (max_age_ff),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .pop_word  (queue_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
